// File: sv/substring_first_match_finder_assert.svh
// assertion macros for the substring first-match finder
`ifndef SUBSTRING_FIRST_MATCH_FINDER_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/smf_pkg.sv
// shared types, constants and helpers for the substring first-match finder
`timescale 1ns / 1ps
package smf_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int TEXT_MAX    = 65536;

  localparam int LEN_W   = 4;
  localparam int WIN_IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int POS_W   = $clog2(TEXT_MAX) + 1;
  localparam int IDX_W   = 16;
  localparam int PDATA_W = 64;
  localparam int PADDR_W = 5;

  // configuration register indexes, byte address is 8 * index
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_CASE_SENSITIVE = 2'd2,
    REG_START_OFFSET   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } out_t;

  typedef struct packed {
    logic [PATTERN_MAX*8-1:0] pattern_bytes;
    logic [LEN_W-1:0]         pattern_length;
    logic                     case_sensitive;
    logic [IDX_W-1:0]         start_offset;
  } cfg_t;

  typedef logic [PATTERN_MAX-1:0][7:0] win_t;

  // fold ascii upper case to lower case unless exact compare
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && (c inside {[8'h41:8'h5A]})) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: sv/smf_cfg_regs.sv
// apb configuration registers of the substring first-match finder
`timescale 1ns / 1ps
module smf_cfg_regs
  import smf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [PATTERN_MAX*8-1:0] pattern_bytes_r;
  logic [LEN_W-1:0]         pattern_length_r;
  logic                     case_sensitive_r;
  logic [IDX_W-1:0]         start_offset_r;
  reg_idx_t                 reg_idx;
  logic                     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;

  // register writes at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      pattern_length_r <= '0;
      case_sensitive_r <= 1'b1;
      start_offset_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_BYTES:  pattern_bytes_r  <= pwdata[PATTERN_MAX*8-1:0];
        REG_PATTERN_LENGTH: pattern_length_r <= pwdata[LEN_W-1:0];
        REG_CASE_SENSITIVE: case_sensitive_r <= pwdata[0];
        REG_START_OFFSET:   start_offset_r   <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_PATTERN_BYTES:  prdata = PDATA_W'(pattern_bytes_r);
      REG_PATTERN_LENGTH: prdata = PDATA_W'(pattern_length_r);
      REG_CASE_SENSITIVE: prdata = PDATA_W'(case_sensitive_r);
      REG_START_OFFSET:   prdata = PDATA_W'(start_offset_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg = '{pattern_bytes:  pattern_bytes_r,
                 pattern_length: pattern_length_r,
                 case_sensitive: case_sensitive_r,
                 start_offset:   start_offset_r};

endmodule

// File: sv/smf_match.sv
// parallel compare of the byte window against the pattern
`timescale 1ns / 1ps
module smf_match
  import smf_pkg::*;
(
  input  win_t             win,
  input  cfg_t             cfg,
  input  logic [LEN_W-1:0] len_eff,
  output logic             hit
);

  logic [PATTERN_MAX-1:0] lane_ok;

  // lane k compares pattern byte k with the window byte len-1-k back
  always_comb begin
    logic [LEN_W-1:0] pos;
    logic [7:0]       pb;
    logic [7:0]       tb;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pos = len_eff - LEN_W'(1) - LEN_W'(k);
      pb  = cfg.pattern_bytes[8*k +: 8];
      tb  = win[pos[WIN_IW-1:0]];
      lane_ok[k] = (LEN_W'(k) >= len_eff) ||
                   (fold_byte(pb, cfg.case_sensitive) == fold_byte(tb, cfg.case_sensitive));
    end
  end

  assign hit = &lane_ok;

endmodule

// File: sv/smf_scan.sv
// stream state: byte window, position and first match latch
`timescale 1ns / 1ps
module smf_scan
  import smf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t result
);

  win_t             win_r, win_nxt, win_shift;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc, start;
  logic             seen_r, seen_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [LEN_W-1:0] len_eff;
  logic             active;
  logic             hit;

  // clamp oversized pattern length
  assign len_eff = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                             : cfg.pattern_length;

  // shifted window with the new byte at entry 0
  always_comb begin
    win_shift[0] = item.text_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_shift[i] = win_r[i-1];
    end
  end

  assign active  = pos_r < POS_W'(TEXT_MAX);
  assign pos_inc = pos_r + POS_W'(1);
  assign start   = pos_inc - POS_W'(len_eff);

  smf_match u_match (
    .win     (win_shift),
    .cfg     (cfg),
    .len_eff (len_eff),
    .hit     (hit)
  );

  // next stream state and result of a last byte
  always_comb begin
    win_nxt   = win_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    if (active) begin
      win_nxt = win_shift;
      pos_nxt = pos_inc;
      if (!seen_r && (len_eff != '0) && (pos_inc >= POS_W'(len_eff)) &&
          (start >= POS_W'(cfg.start_offset)) && hit) begin
        seen_nxt  = 1'b1;
        first_nxt = start[IDX_W-1:0];
      end
    end
    result.found       = seen_nxt;
    result.match_index = seen_nxt ? first_nxt : '0;
    if (item.last_byte) begin
      win_nxt   = '0;
      pos_nxt   = '0;
      seen_nxt  = 1'b0;
      first_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      pos_r   <= '0;
      seen_r  <= 1'b0;
      first_r <= '0;
    end else if (step) begin
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// File: sv/substring_first_match_finder.sv
// top level of the streaming first-match substring finder
//
//  channel  | ports                                     | carries
//  ---------+-------------------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data               | text byte and last-byte mark
//  result   | out_valid, out_ready, out_data            | found flag and match index
//  config   | psel penable pwrite paddr pwdata prdata pready | four registers at 8*i
//
//  one text byte is accepted per cycle unless a last byte waits on a held result.
//  the result of a last byte is loaded into the output register as that byte
//  leaves the input register. only a last byte waits on a held result; other bytes
//  flow through regardless of out_ready. synchronous reset clears the pipeline and
//  the stream state; the registers return to their reset values.
`timescale 1ns / 1ps
`include "substring_first_match_finder_assert.svh"
module substring_first_match_finder
  import smf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  in_t  s1_data_r;
  logic s1_valid_r;
  logic s1_adv;
  out_t result;
  out_t out_data_r;
  logic out_valid_r;

  smf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input stage moves on unless a last byte meets a held result
  assign s1_adv   = s1_valid_r && (!s1_data_r.last_byte || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  smf_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // output register holds the result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_data_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_data_r.last_byte) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `SMF_ASSERT_NOW(a_idx_zero_when_absent, out_valid_r && !out_data_r.found,
                  out_data_r.match_index == '0, "match index set without a match")
  `SMF_ASSERT_NOW(a_idx_after_offset, out_valid_r && out_data_r.found,
                  out_data_r.match_index >= cfg.start_offset, "match before start offset")
  `SMF_ASSERT_NOW(a_last_waits, s1_valid_r && s1_data_r.last_byte && out_valid_r && !out_ready,
                  !in_ready && !s1_adv, "last byte overran a held result")
  `SMF_ASSERT_NEXT(a_result_loaded, s1_adv && s1_data_r.last_byte,
                   out_valid_r, "result of a last byte was lost")

endmodule
